// File: rtl/scre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the signed-count run-length encoder.
package scre_pkg;

  // Widest packet element; positions and counts also fit in this width.
  localparam int unsigned CW = 8;
  // Port widths fixed by the interface.
  localparam int unsigned SampleW = 8;
  localparam int unsigned WordW = 64;
  localparam int unsigned ByteCntW = 4;
  // Bytes per output word and its slot index width.
  localparam int unsigned WordBytes = 8;
  localparam int unsigned SlotW = 3;
  // Depth of the packet command queue between front and back.
  localparam int unsigned QDepth = 2;

  // One closed packet handed from the front to the back.
  typedef struct packed {
    logic [CW-1:0] cnt;          // count element, zero-extended
    logic [CW-1:0] ndata;        // number of data elements, 1 and up
    logic [CW-1:0] first;        // first data element
    logic          last_of_run;  // last packet caused by its request
    logic          stream_done;  // final packet of the stream
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

endpackage

// File: rtl/scre_in_if.sv
`timescale 1ns / 1ps
// Input channel: one sample request with its end-of-stream mark.
interface scre_in_if import scre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               end_of_stream;

  modport source(output valid, output sample, output end_of_stream, input ready);
  modport sink(input valid, input sample, input end_of_stream, output ready);
endinterface

// File: rtl/scre_out_if.sv
`timescale 1ns / 1ps
// Output channel: one packet word request with its byte count and flags.
interface scre_out_if import scre_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WordW-1:0]    out_bytes;
  logic [ByteCntW-1:0] byte_count;
  logic                last_of_run;
  logic                stream_done;

  modport source(output valid, output out_bytes, output byte_count,
                 output last_of_run, output stream_done, input ready);
  modport sink(input valid, input out_bytes, input byte_count,
               input last_of_run, input stream_done, output ready);
endinterface

// File: rtl/signed_count_rle_encoder.sv
`timescale 1ns / 1ps
// Top level of the signed-count run-length encoder.
// Flow: a request that closes a packet pushes its command into the queue; the back loads it,
// writes the packet's bytes into the word in order and registers each full or final word out.
// Input: a request is taken only while the command queue is empty and no literal packet
// drains; a request that closes a packet stalls the front until the back takes it, and a
// literal packet stalls it until the back has finished the packet.
// Reset: asynchronous, active low; clears control state, not the packet buffer.
module signed_count_rle_encoder import scre_pkg::*; #(
  parameter int unsigned ELEM_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scre_in_if.sink    in_i,
  scre_out_if.source out_o
);

  localparam int unsigned AW = ELEM_BITS - 1;
  localparam int unsigned BufDepth = 1 << AW;

  // Front to queue: the packets closed by one request, at most two.
  logic push0, push1;
  cmd_t cmd0, cmd1;

  // Queue to back.
  logic q_empty, q_valid, q_pop;
  cmd_t q_cmd;

  // The back raises this while it reads the packet buffer, so the front never
  // overwrites literals that are still on their way out.
  logic back_busy_lit;

  // Packet buffer holds literal data elements 1 and up of the open packet;
  // element 0 travels in the command itself.
  logic                 buf_we;
  logic [AW-1:0]        buf_waddr, buf_raddr;
  logic [ELEM_BITS-1:0] buf_wdata, buf_rdata;

  scre_front #(
    .ELEM_BITS(ELEM_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .q_empty_i      (q_empty),
    .back_busy_lit_i(back_busy_lit),
    .push0_o        (push0),
    .cmd0_o         (cmd0),
    .push1_o        (push1),
    .cmd1_o         (cmd1),
    .we_o           (buf_we),
    .waddr_o        (buf_waddr),
    .wdata_o        (buf_wdata)
  );

  scre_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(push0),
    .cmd0_i (cmd0),
    .push1_i(push1),
    .cmd1_i (cmd1),
    .empty_o(q_empty),
    .valid_o(q_valid),
    .cmd_o  (q_cmd),
    .pop_i  (q_pop)
  );

  scre_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(BufDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(buf_wdata),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  scre_back #(
    .ELEM_BITS(ELEM_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (q_cmd),
    .q_pop_o   (q_pop),
    .raddr_o   (buf_raddr),
    .rdata_i   (buf_rdata),
    .busy_lit_o(back_busy_lit),
    .out_o     (out_o)
  );

endmodule

// File: rtl/scre_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module scre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/scre_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, tracks the open packet and closes packets.
module scre_front import scre_pkg::*; #(
  parameter int unsigned ELEM_BITS = 8,
  localparam int unsigned AW = ELEM_BITS - 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scre_in_if.sink              in_i,
  input  logic                 q_empty_i,
  input  logic                 back_busy_lit_i,
  output logic                 push0_o,
  output cmd_t                 cmd0_o,
  output logic                 push1_o,
  output cmd_t                 cmd1_o,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [ELEM_BITS-1:0] wdata_o
);

  localparam logic signed [ELEM_BITS-1:0] CntMax = {1'b0, {AW{1'b1}}};
  localparam logic signed [ELEM_BITS-1:0] CntMin = {1'b1, {AW{1'b0}}};
  localparam logic signed [ELEM_BITS-1:0] CntOne = ELEM_BITS'(1);

  // Data elements carried by a packet with count rc.
  function automatic logic [CW-1:0] data_len(input logic signed [ELEM_BITS-1:0] rc);
    logic [ELEM_BITS-1:0] neg;
    neg = -rc;
    return rc[ELEM_BITS-1] ? (CW'(neg) + CW'(1)) : CW'(1);
  endfunction

  function automatic logic [CW-1:0] cnt_elem(input logic signed [ELEM_BITS-1:0] rc);
    return CW'($unsigned(rc));
  endfunction

  logic                        open_q;
  logic signed [ELEM_BITS-1:0] rc_q, rc_n;
  logic [ELEM_BITS-1:0]        prev_q, first_q, first_n, s, neg_rc;
  logic                        accept, eos, has_a, ext;
  cmd_t                        cmd_a, cmd_b;

  assign in_i.ready = q_empty_i && !back_busy_lit_i;
  assign accept     = in_i.valid && in_i.ready;
  assign s          = in_i.sample[ELEM_BITS-1:0];
  assign eos        = in_i.end_of_stream;
  assign neg_rc     = -rc_q;

  always_comb begin
    rc_n    = rc_q;
    first_n = first_q;
    has_a   = 1'b0;
    ext     = 1'b0;
    cmd_a   = '0;
    if (!open_q) begin
      rc_n    = '0;
      first_n = s;
    end else if (s == prev_q) begin
      if (!rc_q[ELEM_BITS-1]) begin
        if (rc_q != CntMax) begin
          rc_n = rc_q + CntOne;
        end else begin
          has_a       = 1'b1;
          cmd_a.cnt   = cnt_elem(rc_q);
          cmd_a.ndata = CW'(1);
          rc_n        = '0;
          first_n     = s;
        end
      end else begin
        // The last literal leaves the literal packet and joins the new repeat.
        has_a       = 1'b1;
        cmd_a.cnt   = cnt_elem(rc_q + CntOne);
        cmd_a.ndata = CW'(neg_rc);
        rc_n        = CntOne;
        first_n     = s;
      end
    end else begin
      if ((rc_q[ELEM_BITS-1] || (rc_q == '0)) && (rc_q != CntMin)) begin
        ext  = 1'b1;
        rc_n = rc_q - CntOne;
      end else begin
        has_a       = 1'b1;
        cmd_a.cnt   = cnt_elem(rc_q);
        cmd_a.ndata = data_len(rc_q);
        rc_n        = '0;
        first_n     = s;
      end
    end
    cmd_a.first       = CW'(first_q);
    cmd_a.last_of_run = !eos;
    cmd_a.stream_done = 1'b0;

    cmd_b.cnt         = cnt_elem(rc_n);
    cmd_b.ndata       = data_len(rc_n);
    cmd_b.first       = CW'(first_n);
    cmd_b.last_of_run = 1'b1;
    cmd_b.stream_done = 1'b1;
  end

  // Data element k of the open packet, k of 1 and up, lives at buffer address k-1.
  assign we_o    = accept && ext;
  assign waddr_o = neg_rc[AW-1:0];
  assign wdata_o = s;

  assign push0_o = accept && (has_a || eos);
  assign cmd0_o  = has_a ? cmd_a : cmd_b;
  assign push1_o = accept && has_a && eos;
  assign cmd1_o  = cmd_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rc_q   <= '0;
      prev_q <= '0;
    end else if (accept) begin
      open_q <= !eos;
      rc_q   <= eos ? '0 : rc_n;
      prev_q <= eos ? '0 : s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= first_n;
    end
  end

endmodule

// File: rtl/scre_cmdq.sv
`timescale 1ns / 1ps
// Two-entry packet command queue, up to two pushes and one pop per cycle.
module scre_cmdq import scre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  cmd_t cmd0_i,
  input  logic push1_i,
  input  cmd_t cmd1_i,
  output logic empty_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            ent_q [QDepth];
  cmd_t            ent_d [QDepth];
  logic [CntW-1:0] cnt_q, cnt_d, cnt_p;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign empty_o = !valid_o;
  assign cmd_o   = ent_q[0];
  assign pop     = pop_i && valid_o;

  always_comb begin
    ent_d = ent_q;
    cnt_p = cnt_q - CntW'(pop);
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    // The second push only comes together with the first, into an empty queue.
    if (push0_i) begin
      ent_d[cnt_p[0]] = cmd0_i;
    end
    if (push1_i) begin
      ent_d[1] = cmd1_i;
    end
    cnt_d = cnt_p + CntW'(push0_i) + CntW'(push1_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// File: rtl/scre_back.sv
`timescale 1ns / 1ps
// Back end: serializes one packet a byte per cycle into 8-byte output words, holding while a full word waits.
module scre_back import scre_pkg::*; #(
  parameter int unsigned ELEM_BITS = 8,
  localparam int unsigned AW = ELEM_BITS - 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 q_pop_o,
  output logic [AW-1:0]        raddr_o,
  input  logic [ELEM_BITS-1:0] rdata_i,
  output logic                 busy_lit_o,
  scre_out_if.source           out_o
);

  back_state_e         state_q, state_d;
  cmd_t                cmd_q;
  logic [CW-1:0]       pos_q, pos_d, rd_pos;
  logic [SlotW-1:0]    slot_q;
  logic [WordW-1:0]    word_q, word_next;
  logic [7:0]          byte_val;
  logic                load, advance, last_byte, word_full, slot_free;
  logic                ov_q;
  logic [WordW-1:0]    ob_q;
  logic [ByteCntW-1:0] bc_q;
  logic                lr_q, sd_q;

  assign slot_free  = !ov_q || out_o.ready;
  assign last_byte  = (pos_q == cmd_q.ndata);
  assign word_full  = (slot_q == SlotW'(WordBytes - 1)) || last_byte;
  assign busy_lit_o = (state_q == BK_RUN) && (cmd_q.ndata > CW'(1));

  // Control outputs of the sequencer.
  always_comb begin
    load    = 1'b0;
    advance = 1'b0;
    unique case (state_q)
      BK_IDLE: load    = q_valid_i;
      BK_RUN:  advance = !word_full || slot_free;
      default: begin
        load    = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_RUN;
      BK_RUN:  if (advance && last_byte) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  assign q_pop_o = load;

  always_comb begin
    if (load) begin
      pos_d = '0;
    end else if (advance) begin
      pos_d = pos_q + CW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Read ahead: the address follows the next position so data lines up.
  assign rd_pos  = pos_d - CW'(2);
  assign raddr_o = rd_pos[AW-1:0];

  always_comb begin
    priority if (pos_q == '0) begin
      byte_val = cmd_q.cnt;
    end else if (pos_q == CW'(1)) begin
      byte_val = cmd_q.first;
    end else begin
      byte_val = 8'(rdata_i);
    end
    word_next = word_q;
    word_next[{slot_q, 3'b000} +: 8] = byte_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      pos_q   <= '0;
      slot_q  <= '0;
      word_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (advance) begin
        slot_q <= word_full ? '0 : slot_q + SlotW'(1);
        word_q <= word_full ? '0 : word_next;
      end
      if (advance && word_full) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (advance && word_full) begin
      ob_q <= word_next;
      bc_q <= {1'b0, slot_q} + ByteCntW'(1);
      lr_q <= last_byte && cmd_q.last_of_run;
      sd_q <= last_byte && cmd_q.stream_done;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_bytes   = ob_q;
  assign out_o.byte_count  = bc_q;
  assign out_o.last_of_run = lr_q;
  assign out_o.stream_done = sd_q;

endmodule

// File: rtl/scre_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the encoder and its bind to the top level.
module scre_checker import scre_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_eos_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [WordW-1:0]    out_bytes_i,
  input logic [ByteCntW-1:0] byte_count_i,
  input logic                last_of_run_i,
  input logic                stream_done_i
);

  logic [2:0] pend_q;
  logic       eos_in, done_out;

  assign eos_in   = in_valid_i && in_ready_i && in_eos_i;
  assign done_out = out_valid_i && out_ready_i && stream_done_i;

  // Stream ends requested but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(eos_in) - 3'(done_out);
    end
  end

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stream_done_i |-> last_of_run_i)
    else $error("stream end word not marked last of its request");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (byte_count_i != '0) &&
                    ((out_bytes_i >> {byte_count_i, 3'b000}) == '0))
    else $error("bad byte count or nonzero unused byte slot");

  a_done_has_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_out |-> pend_q != '0)
    else $error("stream end word without a stream end request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bytes_i) &&
                                    $stable(byte_count_i))
    else $error("stalled output word changed");

endmodule

bind signed_count_rle_encoder scre_checker u_scre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_eos_i     (in_i.end_of_stream),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_bytes_i  (out_o.out_bytes),
  .byte_count_i (out_o.byte_count),
  .last_of_run_i(out_o.last_of_run),
  .stream_done_i(out_o.stream_done)
);
